// ===== hw/rtl/ptsl_pkg.sv =====
// Shared types and constants for the perspective texture span unit.
// Used by ptsl_div, ptsl_tables and perspective_texture_span_lit; no dependencies.
package ptsl_pkg;

   localparam int TEX_SIDE  = 64;
   localparam int COORD_W   = 6;
   localparam int TEX_AW    = 2 * COORD_W;
   localparam int TEX_DEPTH = TEX_SIDE * TEX_SIDE;
   localparam int WORD_W    = 32;
   localparam int BYTE_W    = 8;
   localparam int ADDR_W    = 16;
   localparam int COUNT_W   = 13;
   localparam int REQ_DATA_W = 296;
   localparam logic [BYTE_W-1:0] TRANSPARENT_TEXEL = 8'hFF;

   typedef enum logic [1:0] {
      OP_LOAD_TEXEL = 2'd0,
      OP_LOAD_FADE  = 2'd1,
      OP_START_SPAN = 2'd2,
      OP_STEP_PIXEL = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_TEX,
      ST_FADE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [COORD_W-1:0] tu;
      logic [COORD_W-1:0] tv;
   } coord_type;

   typedef struct packed {
      logic              tex_we;
      logic              fade_we;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } table_wr_type;

endpackage

// ===== hw/rtl/perspective_texture_span_lit.sv =====
// Loads and span starts are taken while idle; configuration writes are always taken.
// A pixel step runs the 32 bit-steps of the shared u/v divider, a texture read, a fade read
// and then loads the output register once any pending result is taken; no request is taken
// meanwhile. A step on a finished span skips the divider and the table reads.
// Reset clears the span state and sets the span finished; the table memories keep
// their contents and must be written before they are read.
module perspective_texture_span_lit #(
   parameter int FADE_LEVELS = 256,
   parameter int MAX_SPAN    = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // From bit 0: table_address[16], table_data[8], u_start, v_start, z_start,
   // light_start, u_step, v_step, z_step, light_step[32 each], pixel_count[13], zero fill.
   input  logic [ptsl_pkg::REQ_DATA_W-1:0]      req_tdata,
   // Bit 0 up: opcode[2].
   input  logic [1:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // Bit 0 up: pixel_color[8].
   output logic [7:0]                           rsp_tdata,
   // Bit 0: write_enable.
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic                                 csr_data
);

   localparam int CNT_W = $clog2(MAX_SPAN + 1);

   ptsl_pkg::state_type  state_ff;
   ptsl_pkg::state_type  state_in;
   ptsl_pkg::opcode_type opcode;

   logic [31:0]      u_acc_ff;
   logic [31:0]      v_acc_ff;
   logic [31:0]      z_acc_ff;
   logic [31:0]      light_acc_ff;
   logic [31:0]      u_inc_ff;
   logic [31:0]      v_inc_ff;
   logic [31:0]      z_inc_ff;
   logic [31:0]      light_inc_ff;
   logic [CNT_W-1:0] pixels_left_ff;
   logic             span_done_ff;
   logic             transparency_ff;
   logic             done_step_ff;
   logic             rsp_tvalid_ff;
   logic [7:0]       rsp_color_ff;
   logic             rsp_we_ff;
   logic             rsp_last_ff;

   logic [15:0]      table_address;
   logic [7:0]       table_data;
   logic [31:0]      u_start;
   logic [31:0]      v_start;
   logic [31:0]      z_start;
   logic [31:0]      light_start;
   logic [31:0]      u_step;
   logic [31:0]      v_step;
   logic [31:0]      z_step;
   logic [31:0]      light_step;
   logic [12:0]      pixel_count;
   logic [12:0]      count_sat;
   logic [31:0]      light_inc_in;

   logic             req_fire;
   logic             div_start;
   logic             div_done;
   logic             tex_rd_en;
   logic             fade_rd_en;
   logic             out_load;
   logic [31:0]      z_next;
   logic [CNT_W-1:0] pixels_next;
   logic             span_end;
   logic [7:0]       fade_level;
   logic [7:0]       texel_q;
   logic [7:0]       color_q;

   ptsl_pkg::coord_type    coord;
   ptsl_pkg::table_wr_type table_wr;

   assign table_address = req_tdata[15:0];
   assign table_data    = req_tdata[23:16];
   assign u_start       = req_tdata[55:24];
   assign v_start       = req_tdata[87:56];
   assign z_start       = req_tdata[119:88];
   assign light_start   = req_tdata[151:120];
   assign u_step        = req_tdata[183:152];
   assign v_step        = req_tdata[215:184];
   assign z_step        = req_tdata[247:216];
   assign light_step    = req_tdata[279:248];
   assign pixel_count   = req_tdata[292:280];
   assign opcode        = ptsl_pkg::opcode_type'(req_tuser);

   assign req_fire  = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   assign count_sat    = (pixel_count > 13'(MAX_SPAN)) ? 13'(MAX_SPAN) : pixel_count;
   assign light_inc_in = {{8{light_step[31]}}, light_step[31:8]} +
                         {31'd0, light_step[31]};

   assign z_next      = z_acc_ff + z_inc_ff;
   assign pixels_next = pixels_left_ff - CNT_W'(1);
   assign span_end    = (pixels_next == '0) || (z_next == '0);
   assign fade_level  = ({1'b0, light_acc_ff[15:8]} >= 9'(FADE_LEVELS)) ?
                        8'(FADE_LEVELS - 1) : light_acc_ff[15:8];

   assign table_wr.tex_we  = req_fire && (opcode == ptsl_pkg::OP_LOAD_TEXEL);
   assign table_wr.fade_we = req_fire && (opcode == ptsl_pkg::OP_LOAD_FADE);
   assign table_wr.addr    = table_address;
   assign table_wr.data    = table_data;

   ptsl_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .u_num (u_acc_ff),
      .v_num (v_acc_ff),
      .den   (z_acc_ff),
      .done  (div_done),
      .coord (coord)
   );

   ptsl_tables #(
      .FADE_LEVELS (FADE_LEVELS)
   ) u_tables (
      .clock        (clock),
      .wr           (table_wr),
      .tex_rd_en    (tex_rd_en),
      .tex_rd_addr  ({coord.tv, coord.tu}),
      .fade_rd_en   (fade_rd_en),
      .fade_rd_addr ({fade_level, texel_q}),
      .texel_q      (texel_q),
      .color_q      (color_q)
   );

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      div_start  = 1'b0;
      tex_rd_en  = 1'b0;
      fade_rd_en = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         ptsl_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && (opcode == ptsl_pkg::OP_STEP_PIXEL)) begin
               if (span_done_ff) begin
                  state_in = ptsl_pkg::ST_OUT;
               end else begin
                  div_start = 1'b1;
                  state_in  = ptsl_pkg::ST_DIV;
               end
            end
         end
         ptsl_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = ptsl_pkg::ST_TEX;
            end
         end
         ptsl_pkg::ST_TEX: begin
            tex_rd_en = 1'b1;
            state_in  = ptsl_pkg::ST_FADE;
         end
         ptsl_pkg::ST_FADE: begin
            fade_rd_en = 1'b1;
            state_in   = ptsl_pkg::ST_OUT;
         end
         ptsl_pkg::ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = ptsl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptsl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptsl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         u_acc_ff        <= '0;
         v_acc_ff        <= '0;
         z_acc_ff        <= '0;
         light_acc_ff    <= '0;
         u_inc_ff        <= '0;
         v_inc_ff        <= '0;
         z_inc_ff        <= '0;
         light_inc_ff    <= '0;
         pixels_left_ff  <= '0;
         span_done_ff    <= 1'b1;
         transparency_ff <= 1'b0;
         done_step_ff    <= 1'b0;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            transparency_ff <= csr_data;
         end
         if (req_fire && (opcode == ptsl_pkg::OP_START_SPAN)) begin
            u_acc_ff       <= u_start;
            v_acc_ff       <= v_start;
            z_acc_ff       <= z_start;
            light_acc_ff   <= {{8{light_start[31]}}, light_start[31:8]};
            u_inc_ff       <= u_step;
            v_inc_ff       <= v_step;
            z_inc_ff       <= z_step;
            light_inc_ff   <= light_inc_in;
            pixels_left_ff <= CNT_W'(count_sat);
            span_done_ff   <= (count_sat == '0) || (z_start == '0);
         end
         if (req_fire && (opcode == ptsl_pkg::OP_STEP_PIXEL)) begin
            done_step_ff <= span_done_ff;
         end
         if (out_load && !done_step_ff) begin
            u_acc_ff       <= u_acc_ff + u_inc_ff;
            v_acc_ff       <= v_acc_ff + v_inc_ff;
            z_acc_ff       <= z_next;
            light_acc_ff   <= light_acc_ff + light_inc_ff;
            pixels_left_ff <= pixels_next;
            span_done_ff   <= span_end;
         end
         if (out_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (done_step_ff) begin
            rsp_color_ff <= '0;
            rsp_we_ff    <= 1'b0;
            rsp_last_ff  <= 1'b1;
         end else begin
            rsp_color_ff <= color_q;
            rsp_we_ff    <= !(transparency_ff && (texel_q == ptsl_pkg::TRANSPARENT_TEXEL));
            rsp_last_ff  <= span_end;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_color_ff;
   assign rsp_tuser  = rsp_we_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_rsp_from_out : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ptsl_pkg::ST_OUT))
      else $error("result raised outside the output state");

   a_div_done_in_div : assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ptsl_pkg::ST_DIV))
      else $error("divider finished while not awaited");

   a_div_live_span : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ptsl_pkg::ST_DIV) |-> !span_done_ff)
      else $error("division running on a finished span");

   a_out_not_lost : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ptsl_pkg::ST_OUT && rsp_tvalid_ff && !rsp_tready) |=>
      (state_ff == ptsl_pkg::ST_OUT))
      else $error("pending result overwritten");

endmodule

// ===== hw/rtl/ptsl_div.sv =====
// Two-lane radix-2 restoring divider producing the low texture coordinate bits
// of u/z and v/z with truncation toward zero. Depends on ptsl_pkg.
module ptsl_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [31:0]             u_num,
   input  logic [31:0]             v_num,
   input  logic [31:0]             den,
   output logic                    done,
   output ptsl_pkg::coord_type     coord
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [31:0] d_ff;
   logic [31:0] un_ff;
   logic [31:0] vn_ff;
   logic [31:0] ur_ff;
   logic [31:0] vr_ff;
   logic        uneg_ff;
   logic        vneg_ff;

   logic [32:0] ut;
   logic [32:0] vt;
   logic [32:0] udiff;
   logic [32:0] vdiff;
   logic        uge;
   logic        vge;
   logic [31:0] ur_in;
   logic [31:0] vr_in;
   logic [31:0] un_in;
   logic [31:0] vn_in;

   always_comb begin
      ut    = {ur_ff, un_ff[31]};
      vt    = {vr_ff, vn_ff[31]};
      udiff = ut - {1'b0, d_ff};
      vdiff = vt - {1'b0, d_ff};
      uge   = (ut >= {1'b0, d_ff});
      vge   = (vt >= {1'b0, d_ff});
      ur_in = uge ? udiff[31:0] : ut[31:0];
      vr_in = vge ? vdiff[31:0] : vt[31:0];
      un_in = {un_ff[30:0], uge};
      vn_in = {vn_ff[30:0], vge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         un_ff   <= u_num[31] ? (~u_num + 32'd1) : u_num;
         vn_ff   <= v_num[31] ? (~v_num + 32'd1) : v_num;
         d_ff    <= den[31] ? (~den + 32'd1) : den;
         ur_ff   <= '0;
         vr_ff   <= '0;
         uneg_ff <= u_num[31] ^ den[31];
         vneg_ff <= v_num[31] ^ den[31];
      end else if (busy_ff) begin
         un_ff <= un_in;
         vn_ff <= vn_in;
         ur_ff <= ur_in;
         vr_ff <= vr_in;
      end
   end

   assign done     = done_ff;
   assign coord.tu = uneg_ff ? (~un_ff[5:0] + 6'd1) : un_ff[5:0];
   assign coord.tv = vneg_ff ? (~vn_ff[5:0] + 6'd1) : vn_ff[5:0];

endmodule

// ===== hw/rtl/ptsl_tables.sv =====
// Texture and fade table memories with registered, enabled reads.
// Depends on ptsl_pkg for widths and the write transaction struct.
module ptsl_tables #(
   parameter int FADE_LEVELS = 256
) (
   input  logic                            clock,
   input  ptsl_pkg::table_wr_type          wr,
   input  logic                            tex_rd_en,
   input  logic [ptsl_pkg::TEX_AW-1:0]     tex_rd_addr,
   input  logic                            fade_rd_en,
   input  logic [ptsl_pkg::ADDR_W-1:0]     fade_rd_addr,
   output logic [ptsl_pkg::BYTE_W-1:0]     texel_q,
   output logic [ptsl_pkg::BYTE_W-1:0]     color_q
);

   localparam int FADE_DEPTH = FADE_LEVELS * 256;
   localparam int FADE_AW    = $clog2(FADE_DEPTH);

   logic [ptsl_pkg::BYTE_W-1:0] tex_mem  [ptsl_pkg::TEX_DEPTH];
   logic [ptsl_pkg::BYTE_W-1:0] fade_mem [FADE_DEPTH];

   logic tex_wr_ok;
   logic fade_wr_ok;

   assign tex_wr_ok  = wr.tex_we &&
                       (wr.addr[ptsl_pkg::ADDR_W-1:ptsl_pkg::TEX_AW] == '0);
   assign fade_wr_ok = wr.fade_we && ({1'b0, wr.addr} < 17'(FADE_DEPTH));

   always_ff @(posedge clock) begin
      if (tex_wr_ok) begin
         tex_mem[wr.addr[ptsl_pkg::TEX_AW-1:0]] <= wr.data;
      end
      if (tex_rd_en) begin
         texel_q <= tex_mem[tex_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (fade_wr_ok) begin
         fade_mem[wr.addr[FADE_AW-1:0]] <= wr.data;
      end
      if (fade_rd_en) begin
         color_q <= fade_mem[fade_rd_addr[FADE_AW-1:0]];
      end
   end

endmodule
